@@ sv/ksp_pkg.sv @@
// Package for the Kronecker symbol unit: widths, the p = 2 table and codes.
// Used by kronecker_symbol_prime_unit and its testbench.
package ksp_pkg;

  localparam int unsigned VALUE_BITS_DEF   = 64;
  localparam int unsigned MODULUS_BITS_DEF = 31;
  localparam int unsigned SYMBOL_BITS      = 2;

  localparam logic [SYMBOL_BITS-1:0] SYM_ZERO = 2'd0;
  localparam logic [SYMBOL_BITS-1:0] SYM_POS  = 2'd1;
  localparam logic [SYMBOL_BITS-1:0] SYM_NEG  = 2'd3;

  // symbol (d/2) indexed by d mod 8
  function automatic logic [SYMBOL_BITS-1:0] two_symbol(input logic [2:0] idx);
    logic [SYMBOL_BITS-1:0] s;
    case (idx)
      3'd1, 3'd7: s = SYM_POS;
      3'd3, 3'd5: s = SYM_NEG;
      default:    s = SYM_ZERO;
    endcase
    return s;
  endfunction

endpackage

@@ sv/ksp_modmul.sv @@
// Bit-serial modular multiply a*b mod m, one bit of b per cycle (shift-add).
// Depends on nothing outside this file; widths come from the MODULUS_BITS parameter.
module ksp_modmul #(
  parameter int unsigned MODULUS_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [MODULUS_BITS-1:0] a,
  input  logic [MODULUS_BITS-1:0] b,
  input  logic [MODULUS_BITS-1:0] m,
  output logic                    done,
  output logic [MODULUS_BITS-1:0] prod
);

  localparam int unsigned CW = $clog2(MODULUS_BITS + 1);

  logic [MODULUS_BITS-1:0] acc, mult, bsh;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic [MODULUS_BITS+1:0] dbl, dbl_r, add, add_r;

  // Horner step from the top bit of b: acc = 2*acc (+ a), reduced each time
  always_comb begin
    dbl   = {1'b0, acc, 1'b0};
    dbl_r = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
    add   = dbl_r + {2'b00, mult};
    add_r = (add >= {2'b00, m}) ? add - {2'b00, m} : add;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      acc  <= '0;
      mult <= a;
      bsh  <= b;
      cnt  <= CW'(MODULUS_BITS);
    end else if (busy) begin
      acc <= bsh[MODULUS_BITS-1] ? add_r[MODULUS_BITS-1:0] : dbl_r[MODULUS_BITS-1:0];
      bsh <= bsh << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign prod = acc;

endmodule

@@ sv/kronecker_symbol_prime_unit.sv @@
// Top level: Kronecker symbol (d/p) for prime p by Euler's criterion.
// Depends on ksp_pkg and ksp_modmul.
//
//  channel | dir | tdata fields (low bit up)       | tuser
//  s_axis  | in  | value, modulus (zero padded)    | -
//  m_axis  | out | symbol (zero padded to 8 bits)  | -
//
// One request at a time. Reduction of |d| mod p is bit-serial. The power takes up
// to 2*(MODULUS_BITS-1) modular multiplies on the shared bit-serial multiplier.
// p = 2 and p <= 1 finish at once.
// Synchronous reset clears control; a stalled result holds and blocks new requests.
module kronecker_symbol_prime_unit #(
  parameter int unsigned VALUE_BITS   = ksp_pkg::VALUE_BITS_DEF,
  parameter int unsigned MODULUS_BITS = ksp_pkg::MODULUS_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // value [VALUE_BITS-1:0], modulus above it, zeros to a whole byte
  input  logic [((VALUE_BITS+MODULUS_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // symbol [1:0], zeros above
  output logic [7:0] m_axis_tdata
);

  localparam int unsigned VW = VALUE_BITS;
  localparam int unsigned MW = MODULUS_BITS;
  localparam int unsigned VC = $clog2(VW + 1);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_CHK, S_MUL, S_SQR, S_WAIT, S_OUT} state_t;

  state_t             state;
  logic [VW-1:0]      mag;
  logic [MW:0]        rem;
  logic [MW-1:0]      p, base, acc, expo;
  logic               neg, sq_pending;
  logic [VC-1:0]      vcnt;
  logic [1:0]         sym;

  logic [VW-1:0]      in_val;
  logic [MW-1:0]      in_mod;
  logic [MW:0]        rsh, rsub;
  logic [MW-1:0]      half_pm1;

  logic               mm_start, mm_done;
  logic [MW-1:0]      mm_a, mm_b, mm_prod;

  assign in_val = s_axis_tdata[VW-1:0];
  assign in_mod = s_axis_tdata[VW+MW-1:VW];

  // restoring remainder step: shift in the next magnitude bit
  assign rsh  = {rem[MW-1:0], mag[VW-1]};
  assign rsub = (rsh >= {1'b0, p}) ? rsh - {1'b0, p} : rsh;

  // exponent (p-1)/2
  assign half_pm1 = (p - MW'(1)) >> 1;

  assign mm_start = (state == S_MUL) || (state == S_SQR);
  assign mm_a     = (state == S_MUL) ? acc : base;
  assign mm_b     = base;

  ksp_modmul #(.MODULUS_BITS(MW)) u_mul (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(p),
    .done(mm_done), .prod(mm_prod)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {6'd0, sym};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          p    <= in_mod;
          neg  <= in_val[VW-1];
          mag  <= in_val[VW-1] ? VW'(~in_val + 1'b1) : in_val;
          rem  <= '0;
          vcnt <= VC'(VW);
          if (in_mod == MW'(2)) begin
            sym   <= ksp_pkg::two_symbol(in_val[2:0]);
            state <= S_OUT;
          end else if (in_mod <= MW'(1)) begin
            sym   <= ksp_pkg::SYM_ZERO;
            state <= S_OUT;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: begin
          rem  <= rsub;
          mag  <= mag << 1;
          vcnt <= vcnt - 1'b1;
          if (vcnt == VC'(1)) state <= S_CHK;
        end
        S_CHK: begin
          if (rem == '0) begin
            sym   <= ksp_pkg::SYM_ZERO;
            state <= S_OUT;
          end else begin
            base  <= neg ? p - rem[MW-1:0] : rem[MW-1:0];
            acc   <= MW'(1);
            expo  <= half_pm1;
            state <= S_SQR;
            if (half_pm1 == '0) begin
              sym   <= ksp_pkg::SYM_POS;
              state <= S_OUT;
            end else if (half_pm1[0]) begin
              // exponent bit 0 set: multiply then square
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          sq_pending <= 1'b1;
          state      <= S_WAIT;
        end
        S_SQR: begin
          sq_pending <= 1'b0;
          state      <= S_WAIT;
        end
        S_WAIT: if (mm_done) begin
          if (sq_pending) begin
            acc   <= mm_prod;
            state <= S_SQR;
          end else begin
            base <= mm_prod;
            expo <= expo >> 1;
            if ((expo >> 1) == '0) begin
              sym   <= (acc == MW'(1)) ? ksp_pkg::SYM_POS : ksp_pkg::SYM_NEG;
              state <= S_OUT;
            end else begin
              state <= expo[1] ? S_MUL : S_SQR;
            end
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/kronecker_symbol_prime_unit_tb.sv @@
// Testbench for kronecker_symbol_prime_unit: drives (value, modulus) requests,
// predicts the symbol by Euler's criterion and checks every result in order.
// Depends on ksp_pkg and the unit RTL.
`timescale 1ns / 100ps

module kronecker_symbol_prime_unit_tb;

  localparam int VB = 64;
  localparam int MB = 31;
  localparam int DW = ((VB + MB + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int NUM_RANDOM = 1400;

  typedef struct packed {
    logic [MB-1:0] modulus;
    logic [VB-1:0] value;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  request_t pending_requests[$];
  logic [1:0] expected_symbols[$];
  int mismatch_count = 0;
  int stall_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit stimulus_done = 1'b0;
  bit idle_free = 1'b0;

  always #5 clk = ~clk;

  kronecker_symbol_prime_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a * b) % m;
  endfunction

  function automatic logic [1:0] kronecker_symbol(request_t req);
    logic [63:0] p, mag, r, acc, base, e;
    logic neg;
    p = 64'(req.modulus);
    if (p == 0) return ksp_pkg::SYM_ZERO;
    if (p == 2) return ksp_pkg::two_symbol(req.value[2:0]);
    neg = req.value[VB-1];
    mag = neg ? (~req.value + 64'd1) : req.value;
    r = mag % p;
    if (r == 0) return ksp_pkg::SYM_ZERO;
    if (neg) r = p - r;
    acc = 64'd1 % p;
    base = r;
    e = (p - 1) >> 1;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, p);
      base = mulmod(base, base, p);
      e = e >> 1;
    end
    return (acc == 1) ? ksp_pkg::SYM_POS : ksp_pkg::SYM_NEG;
  endfunction

  function automatic int gap_draw();
    return idle_free ? 0 : ((($urandom_range(0, 3)) == 0) ? 0 : $urandom_range(0, 14));
  endfunction

  // small primes keep the power short; a few large ones exercise full width
  function automatic logic [MB-1:0] pick_modulus();
    int unsigned primes[12] = '{3, 5, 7, 11, 13, 101, 65521, 1000003,
                                 2147483647, 2147483629, 999999937, 131071};
    case ($urandom_range(0, 9))
      0: return MB'(2);
      1: return MB'($urandom_range(0, 1));
      2: return MB'($urandom);
      3: return MB'($urandom_range(3, 4000));
      default: return MB'(primes[$urandom_range(0, 11)]);
    endcase
  endfunction

  function automatic logic [VB-1:0] pick_value(logic [MB-1:0] p);
    case ($urandom_range(0, 5))
      0: return 64'(p) * $urandom_range(0, 1000);
      1: return -(64'(p) * $urandom_range(1, 1000));
      2: return $signed(64'($urandom_range(0, 40))) - 64'(20);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_request(logic [VB-1:0] v, logic [MB-1:0] p);
    request_t req;
    req.value = v;
    req.modulus = p;
    pending_requests.push_back(req);
  endtask

  // driver: hold the request until accepted, then wait a drawn gap
  always @(posedge clk) begin
    if (!rst) begin
      int gap;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_symbols.push_back(kronecker_symbol(request_t'(s_axis_tdata[VB+MB-1:0])));
        gap = gap_draw();
        if (gap == 0 && pending_requests.size() > 0) begin
          s_axis_tdata <= DW'(pending_requests.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          send_gap <= gap;
          s_axis_tvalid <= 1'b0;
        end
      end else if (!s_axis_tvalid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() > 0) begin
          s_axis_tdata <= DW'(pending_requests.pop_front());
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // monitor: compare accepted results, then stall ready for a drawn count
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_symbols.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: symbol %0d", m_axis_tdata[1:0]);
        end else begin
          logic [1:0] exp_sym;
          exp_sym = expected_symbols.pop_front();
          if (m_axis_tdata !== {6'd0, exp_sym}) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("symbol mismatch: expected %0d got %0d", exp_sym, m_axis_tdata);
          end
        end
        recv_gap = gap_draw();
        m_axis_tready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= (recv_gap == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [MB-1:0] p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: field extremes, p = 0, 1, 2 table, divisible, negative values
    for (int i = 0; i < 8; i++) add_request(64'(i) - 64'(8 * i * 3), MB'(2));
    add_request(64'h7FFF_FFFF_FFFF_FFFF, MB'(2));
    add_request(64'h8000_0000_0000_0000, MB'(2));
    add_request(64'(12345), MB'(0));
    add_request(64'(-1), MB'(1));
    add_request(64'(0), MB'(7));
    add_request(64'(-14), MB'(7));
    add_request(64'(-1), MB'(7));
    add_request(64'(3), MB'(7));
    add_request(64'h8000_0000_0000_0000, 31'h7FFF_FFFF);
    add_request(64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
    add_request(64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
    add_request(64'(2), 31'h7FFF_FFFF);
    add_request(64'h5555_5555_AAAA_AAAA, 31'h5555_5555);
    add_request(64'hAAAA_AAAA_5555_5555, 31'h2AAA_AAAA);
    add_request(64'(-5), MB'(9));
    add_request(64'(5), MB'(8));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      p = pick_modulus();
      add_request(pick_value(p), p);
    end
    // last stretch runs without idling
    wait (pending_requests.size() < 60);
    idle_free = 1'b1;
    wait (pending_requests.size() == 0);
    @(negedge clk);
    wait (!s_axis_tvalid);
    wait (expected_symbols.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_symbols.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
sv/ksp_pkg.sv
sv/ksp_modmul.sv
sv/kronecker_symbol_prime_unit.sv
dv/kronecker_symbol_prime_unit_tb.sv
